>>> design/scmv_pkg.sv
// Shared types and constants for the sparse CSC mat-vec accumulate core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package scmv_pkg;

  localparam int unsigned IDX_W            = 10;
  localparam int unsigned OP_W             = 32;
  localparam int unsigned SUM_W            = 48;
  localparam int unsigned FRAC_W           = 16;
  localparam int unsigned PROD_W           = 2 * OP_W;
  localparam int unsigned VECTOR_DEPTH_DEF = 1024;
  localparam int unsigned ROW_DEPTH_DEF    = 1024;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ACCUM = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef struct packed {
    req_e                    req_type;
    logic [IDX_W-1:0]        col_index;
    logic [IDX_W-1:0]        row_index;
    logic signed [OP_W-1:0]  operand;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic                    overflowed;
  } out_item_t;

  // Per-stage control of an item that touches the row sums.
  typedef struct packed {
    logic             valid;
    logic             accum;
    logic             read;
    logic             row_ok;
    logic [IDX_W-1:0] row;
  } op_ctl_t;

endpackage

>>> design/scmv_vec_mem.sv
// Input-vector RAM: one write port, one registered read port.
// Depends on scmv_pkg.
`timescale 1ns / 1ps

module scmv_vec_mem #(
  parameter int unsigned VECTOR_DEPTH = scmv_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [scmv_pkg::IDX_W-1:0]       wr_addr_i,
  input  logic signed [scmv_pkg::OP_W-1:0] wr_data_i,
  input  logic                             rd_en_i,
  input  logic [scmv_pkg::IDX_W-1:0]       rd_addr_i,
  output logic signed [scmv_pkg::OP_W-1:0] rd_data_o
);

  localparam int unsigned AddrW = $clog2(VECTOR_DEPTH);

  logic signed [scmv_pkg::OP_W-1:0] mem [VECTOR_DEPTH];
  logic signed [scmv_pkg::OP_W-1:0] rd_data_q;
  logic [AddrW-1:0]                 wr_addr;
  logic [AddrW-1:0]                 rd_addr;

  assign wr_addr   = AddrW'(wr_addr_i);
  assign rd_addr   = AddrW'(rd_addr_i);
  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

>>> design/scmv_row_acc.sv
// Row-sum RAM with sticky overflow flags, read-modify-write with a one-deep
// bypass, saturating add, and the clearing sweep after reset. Depends on scmv_pkg.
`timescale 1ns / 1ps

module scmv_row_acc #(
  parameter int unsigned ROW_DEPTH = scmv_pkg::ROW_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  scmv_pkg::op_ctl_t                 rd_ctl_i,
  input  scmv_pkg::op_ctl_t                 wb_ctl_i,
  input  logic signed [scmv_pkg::SUM_W-1:0] prod_i,
  output logic                              busy_o,
  output scmv_pkg::out_item_t               result_o
);

  localparam int unsigned AddrW = $clog2(ROW_DEPTH);

  typedef struct packed {
    logic                              flag;
    logic signed [scmv_pkg::SUM_W-1:0] sum;
  } entry_t;

  entry_t                          mem [ROW_DEPTH];
  entry_t                          rd_q;
  logic                            clr_busy_q, clr_busy_d;
  logic [AddrW-1:0]                clr_addr_q, clr_addr_d;

  logic                            we;
  logic [AddrW-1:0]                wa;
  entry_t                          wd;
  logic [AddrW-1:0]                ra;
  logic                            re;
  logic [scmv_pkg::SUM_W:0]        sum_wide;
  logic                            ovf;
  entry_t                          acc;

  // Saturating add of the truncated product into the row sum
  always_comb begin
    sum_wide = {rd_q.sum[scmv_pkg::SUM_W-1], rd_q.sum}
             + {prod_i[scmv_pkg::SUM_W-1], prod_i};
    ovf      = sum_wide[scmv_pkg::SUM_W] ^ sum_wide[scmv_pkg::SUM_W-1];
    acc.flag = rd_q.flag | ovf;
    if (!ovf) begin
      acc.sum = sum_wide[scmv_pkg::SUM_W-1:0];
    end else if (sum_wide[scmv_pkg::SUM_W]) begin
      acc.sum = scmv_pkg::SUM_MIN;
    end else begin
      acc.sum = scmv_pkg::SUM_MAX;
    end
  end

  // Write port: clearing sweep, else writeback (a read clears its row)
  always_comb begin
    we = 1'b0;
    wa = clr_addr_q;
    wd = '0;
    if (clr_busy_q) begin
      we = 1'b1;
    end else if (en_i && wb_ctl_i.valid && wb_ctl_i.row_ok) begin
      we = 1'b1;
      wa = AddrW'(wb_ctl_i.row);
      wd = wb_ctl_i.accum ? acc : '0;
    end
  end

  assign ra = AddrW'(rd_ctl_i.row);
  assign re = en_i && rd_ctl_i.valid && rd_ctl_i.row_ok;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      // same-row update in the writeback stage this cycle
      rd_q <= (we && (wa == ra)) ? wd : mem[ra];
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(ROW_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign busy_o = clr_busy_q;

  always_comb begin
    result_o = '0;
    if (wb_ctl_i.row_ok) begin
      result_o.row_sum    = rd_q.sum;
      result_o.overflowed = rd_q.flag;
    end
  end

endmodule

>>> design/sparse_csc_matvec_accumulate_core.sv
// Sparse CSC mat-vec accumulate core: Q16.16 products summed into Q32.16 row sums.
// A read item passes stages s1 and s2 and then the output register before its result is valid.
// Throughput: one item per cycle while in_stall_o is low; the row-sum RAM is read and written once per cycle.
// The pipeline halts only while a read result is stalled at the output.
// Reset: after rst_ni is released the row sums and flags are swept to zero,
// every row in turn, with in_stall_o high.
`timescale 1ns / 1ps

module sparse_csc_matvec_accumulate_core #(
  parameter int unsigned VECTOR_DEPTH = scmv_pkg::VECTOR_DEPTH_DEF,
  parameter int unsigned ROW_DEPTH    = scmv_pkg::ROW_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scmv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scmv_pkg::out_item_t out_item_o
);

  logic                              accept;
  logic                              en;
  logic                              busy;
  logic                              col_ok;
  logic                              row_ok;
  logic                              is_load;
  logic                              is_accum;
  logic                              is_read;
  scmv_pkg::op_ctl_t                 s1_q, s1_d;
  scmv_pkg::op_ctl_t                 s2_q;
  logic signed [scmv_pkg::OP_W-1:0]  op_q;
  logic signed [scmv_pkg::OP_W-1:0]  vec_rd;
  logic signed [scmv_pkg::PROD_W-1:0] prod_full;
  logic signed [scmv_pkg::SUM_W-1:0] prod_q;
  scmv_pkg::out_item_t               result;
  logic                              out_valid_q;
  scmv_pkg::out_item_t               out_item_q;

  // Everything advances together unless a read result in s2 is blocked by a stalled result at the output.
  assign en         = !(out_valid_q && out_stall_i && s2_q.valid && s2_q.read);
  assign in_stall_o = busy || !en;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_ok   = 32'(in_item_i.col_index) < 32'(VECTOR_DEPTH);
  assign row_ok   = 32'(in_item_i.row_index) < 32'(ROW_DEPTH);
  assign is_load  = in_item_i.req_type == scmv_pkg::REQ_LOAD;
  assign is_accum = in_item_i.req_type == scmv_pkg::REQ_ACCUM;
  assign is_read  = in_item_i.req_type == scmv_pkg::REQ_READ;

  always_comb begin
    s1_d.valid  = accept && ((is_accum && col_ok && row_ok) || is_read);
    s1_d.accum  = is_accum;
    s1_d.read   = is_read;
    s1_d.row_ok = row_ok;
    s1_d.row    = in_item_i.row_index;
  end

  scmv_vec_mem #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_vec_mem (
    .clk_i    (clk_i),
    .wr_en_i  (accept && is_load && col_ok),
    .wr_addr_i(in_item_i.col_index),
    .wr_data_i(in_item_i.operand),
    .rd_en_i  (accept && is_accum && col_ok),
    .rd_addr_i(in_item_i.col_index),
    .rd_data_o(vec_rd)
  );

  // Q16.16 x Q16.16 = Q32.32; dropping 16 fraction bits floors the value.
  assign prod_full = op_q * vec_rd;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_item_i.operand;
    end
    if (en) begin
      prod_q <= prod_full[scmv_pkg::PROD_W-1:scmv_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  scmv_row_acc #(
    .ROW_DEPTH(ROW_DEPTH)
  ) u_row_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .rd_ctl_i(s1_q),
    .wb_ctl_i(s2_q),
    .prod_i  (prod_q),
    .busy_o  (busy),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && s2_q.valid && s2_q.read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_q.valid && s2_q.read) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> design/scmv_checker.sv
// Port-level checks for the sparse CSC mat-vec accumulate core, bound to the top.
// Depends on scmv_pkg.
`timescale 1ns / 1ps

module scmv_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input scmv_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input scmv_pkg::out_item_t out_item_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // row sums are being cleared right after reset, so no item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("item accepted during clearing sweep");

  // no result can be pending right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a read item must pass stages s1 and s2 before its result is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) ##1 1'b1 |-> !out_valid_o)
    else $error("result valid too early after reset");

endmodule

bind sparse_csc_matvec_accumulate_core scmv_checker u_scmv_checker (.*);
